[sv/dfaj_pkg.sv]
`timescale 1ns / 1ps
package dfaj_pkg;

    // Default sizing
    localparam int CAPACITY_DEF  = 64;
    localparam int ATOM_BITS_DEF = 20;

    // Result status codes
    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_FULL  = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_FULL
    } dfaj_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;     // latch the incoming angle
        logic mem_we;     // store the incoming angle
        logic rd_en;      // read one stored angle
        logic consume;    // compare slot holds an entry that is used this cycle
        logic flush;      // move held dihedral to output as last of run
        logic emit_full;  // emit the store-full result
    } dfaj_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic match;       // stored entry overlaps the current angle
        logic pend_valid;  // a dihedral is held back awaiting its successor
        logic out_free;    // output register can take a transaction this cycle
    } dfaj_stat_t;

endpackage

[sv/dfaj_ctrl.sv]
`timescale 1ns / 1ps
module dfaj_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          first_of_set,
    input  dfaj_pkg::dfaj_stat_t          stat,
    output dfaj_pkg::dfaj_cmd_t           cmd,
    output logic [$clog2(CAPACITY)-1:0]   wr_addr,
    output logic [$clog2(CAPACITY)-1:0]   rd_addr
);
    import dfaj_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    dfaj_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0] count_eff;
    logic             stall;

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    assign count_eff = first_of_set ? '0 : count_reg;
    assign wr_addr   = count_eff[IDX_W-1:0];
    assign rd_addr   = idx_reg[IDX_W-1:0];
    assign in_ready  = (state_reg == ST_IDLE);

    // A match with a dihedral already held must wait for room at the output
    assign stall = cmp_valid_reg && stat.match && stat.pend_valid && !stat.out_free;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmd            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    count_next = count_eff;
                    idx_next   = '0;
                    if (count_eff >= CAP_CNT)
                    begin
                        state_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.mem_we = 1'b1;
                        state_next = (count_eff == '0) ? ST_FLUSH : ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                cmd.consume = cmp_valid_reg && !stall;
                if ((idx_reg < count_reg) && (!cmp_valid_reg || cmd.consume))
                begin
                    cmd.rd_en      = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                end
                else if (cmd.consume)
                begin
                    cmp_valid_next = 1'b0;
                end
                if ((idx_reg == count_reg) && (cmd.consume || !cmp_valid_reg))
                begin
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    count_next = count_reg + 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_FULL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_full = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/dfaj_dpath.sv]
`timescale 1ns / 1ps
module dfaj_dpath #(
    parameter int CAPACITY  = 64,
    parameter int ATOM_BITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dfaj_pkg::dfaj_cmd_t           cmd,
    output dfaj_pkg::dfaj_stat_t          stat,
    input  logic [$clog2(CAPACITY)-1:0]   wr_addr,
    input  logic [$clog2(CAPACITY)-1:0]   rd_addr,
    input  logic [ATOM_BITS-1:0]          end_atom_a,
    input  logic [ATOM_BITS-1:0]          middle_atom,
    input  logic [ATOM_BITS-1:0]          end_atom_b,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ATOM_BITS-1:0]          chain_atom_1,
    output logic [ATOM_BITS-1:0]          chain_atom_2,
    output logic [ATOM_BITS-1:0]          chain_atom_3,
    output logic [ATOM_BITS-1:0]          chain_atom_4,
    output logic                          status,
    output logic                          last_of_run
);
    import dfaj_pkg::*;

    localparam int ENTRY_W = 3 * ATOM_BITS;
    localparam int CHAIN_W = 4 * ATOM_BITS;

    logic [ENTRY_W-1:0]   store_mem [CAPACITY];
    logic [ENTRY_W-1:0]   rdata_reg;
    logic [ATOM_BITS-1:0] n1_reg, n2_reg, n3_reg;
    logic [CHAIN_W-1:0]   pend_reg;
    logic                 pend_valid_reg;
    logic [CHAIN_W-1:0]   out_chain_reg;
    logic                 out_status_reg;
    logic                 out_last_reg;
    logic                 out_valid_reg;

    logic [ATOM_BITS-1:0] p1, p2, p3;
    logic                 hit;
    logic [CHAIN_W-1:0]   chain;
    logic                 out_free;
    logic                 push;

    // Angle store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            store_mem[wr_addr] <= {end_atom_a, middle_atom, end_atom_b};
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    // Current angle
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            n1_reg <= end_atom_a;
            n2_reg <= middle_atom;
            n3_reg <= end_atom_b;
        end
    end

    assign p1 = rdata_reg[ENTRY_W-1 -: ATOM_BITS];
    assign p2 = rdata_reg[2*ATOM_BITS-1 -: ATOM_BITS];
    assign p3 = rdata_reg[ATOM_BITS-1:0];

    // Overlap cases in priority order, with chain orientation
    always_comb
    begin
        hit   = 1'b1;
        chain = '0;
        if (p1 == n2_reg && p2 == n3_reg)
        begin
            if ((p1 > p2) || (p1 == p2 && n1_reg > p3))
                chain = {p3, p2, p1, n1_reg};
            else
                chain = {n1_reg, p1, p2, p3};
        end
        else if (p1 == n2_reg && p2 == n1_reg)
        begin
            if ((p1 > p2) || (p1 == p2 && n3_reg > p3))
                chain = {p3, p2, p1, n3_reg};
            else
                chain = {n3_reg, p1, p2, p3};
        end
        else if (p2 == n1_reg && p3 == n2_reg)
        begin
            if ((p2 > p3) || (p2 == p3 && p1 > n3_reg))
                chain = {n3_reg, p3, p2, p1};
            else
                chain = {p1, p2, p3, n3_reg};
        end
        else if (p2 == n3_reg && p3 == n2_reg)
        begin
            if ((p2 > p3) || (p2 == p3 && p1 > n1_reg))
                chain = {n1_reg, p3, p2, p1};
            else
                chain = {p1, p2, p3, n1_reg};
        end
        else
        begin
            hit = 1'b0;
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign push     = cmd.consume && hit;

    // Held dihedral: released when the next one arrives or at end of scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (push)
            pend_valid_reg <= 1'b1;
        else if (cmd.flush)
            pend_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            pend_reg <= chain;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((push && pend_valid_reg) || cmd.flush || cmd.emit_full)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push && pend_valid_reg)
        begin
            out_chain_reg  <= pend_reg;
            out_status_reg <= STATUS_FOUND;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.flush)
        begin
            out_chain_reg  <= pend_reg;
            out_status_reg <= STATUS_FOUND;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.emit_full)
        begin
            out_chain_reg  <= '0;
            out_status_reg <= STATUS_FULL;
            out_last_reg   <= 1'b1;
        end
    end

    assign stat.match      = hit;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    assign out_valid    = out_valid_reg;
    assign chain_atom_1 = out_chain_reg[CHAIN_W-1 -: ATOM_BITS];
    assign chain_atom_2 = out_chain_reg[3*ATOM_BITS-1 -: ATOM_BITS];
    assign chain_atom_3 = out_chain_reg[2*ATOM_BITS-1 -: ATOM_BITS];
    assign chain_atom_4 = out_chain_reg[ATOM_BITS-1:0];
    assign status       = out_status_reg;
    assign last_of_run  = out_last_reg;

endmodule

[sv/dihedral_from_angle_join.sv]
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// input    in_valid / in_ready   first_of_set, end_atom_a, middle_atom, end_atom_b
// output   out_valid / out_ready chain_atom_1..4, status, last_of_run
//
// One angle is taken at a time. An item passes an accept step, a scan that reads
// one store entry per cycle through the store's single registered read port while
// the output does not stall it, and a flush step; an empty store skips the scan. A
// full store goes from accept straight to the store-full result.
// rst_n clears the FSM, the entry count and the output; the store is not cleared.
// A stalled output holds the scan at the next matching entry; in_ready is high
// only between items, also while the last result still waits at the output.
module dihedral_from_angle_join #(
    parameter int CAPACITY  = dfaj_pkg::CAPACITY_DEF,
    parameter int ATOM_BITS = dfaj_pkg::ATOM_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 first_of_set,
    input  logic [ATOM_BITS-1:0] end_atom_a,
    input  logic [ATOM_BITS-1:0] middle_atom,
    input  logic [ATOM_BITS-1:0] end_atom_b,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ATOM_BITS-1:0] chain_atom_1,
    output logic [ATOM_BITS-1:0] chain_atom_2,
    output logic [ATOM_BITS-1:0] chain_atom_3,
    output logic [ATOM_BITS-1:0] chain_atom_4,
    output logic                 status,
    output logic                 last_of_run
);
    import dfaj_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    dfaj_cmd_t        cmd;
    dfaj_stat_t       stat;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    // Sequencer
    dfaj_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first_of_set (first_of_set),
        .stat         (stat),
        .cmd          (cmd),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr)
    );

    // Store, compare and output
    dfaj_dpath #(
        .CAPACITY  (CAPACITY),
        .ATOM_BITS (ATOM_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr),
        .end_atom_a   (end_atom_a),
        .middle_atom  (middle_atom),
        .end_atom_b   (end_atom_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .chain_atom_1 (chain_atom_1),
        .chain_atom_2 (chain_atom_2),
        .chain_atom_3 (chain_atom_3),
        .chain_atom_4 (chain_atom_4),
        .status       (status),
        .last_of_run  (last_of_run)
    );

endmodule
